// File: rtl/running_mean_variance_xy_defines.svh
// assertion macros for the running mean and variance block
// no dependencies
`ifndef RUNNING_MEAN_VARIANCE_XY_DEFINES_SVH
`define RUNNING_MEAN_VARIANCE_XY_DEFINES_SVH
`define RMV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RMV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/rmv_pkg.sv
// package for the running mean and variance block: widths and constants
// no dependencies
package rmv_pkg;
  localparam int CoordBits = 16;
  localparam int CountBits = 32;
  localparam int FracBits  = 16;
  localparam int M2Shift   = 24;
  localparam int DivBits   = 64;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam logic [39:0] VarMax = {40{1'b1}};
endpackage

// File: rtl/rmv_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on rmv_pkg
module rmv_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rmv_pkg::DivBits-1:0]   num_i,
  input  logic [rmv_pkg::CountBits-1:0] den_i,
  output logic                          done_o,
  output logic [rmv_pkg::DivBits-1:0]   quo_o
);
  import rmv_pkg::*;
  logic [DivBits-1:0] q_q, q_d;
  logic [CountBits-1:0] r_q, r_d;
  logic [CountBits-1:0] den_q, den_d;
  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [CountBits:0] trial;
  always_comb begin
    q_d = q_q; r_d = r_q; den_d = den_q; cnt_d = cnt_q; busy_d = busy_q;
    done_d = 1'b0;
    trial = {r_q, q_q[DivBits-1]};
    if (start_i) begin
      q_d = num_i; r_d = '0; den_d = den_i; cnt_d = 7'(DivBits); busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        r_d = CountBits'(trial - {1'b0, den_q});
        q_d = {q_q[DivBits-2:0], 1'b1};
      end else begin
        r_d = trial[CountBits-1:0];
        q_d = {q_q[DivBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end
  assign done_o = done_q;
  assign quo_o = q_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end
  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; den_q <= den_d;
  end
endmodule

// File: rtl/rmv_mul.sv
// shift-add multiplier, one multiplier bit per cycle, 48 by 48 bits
// depends on rmv_pkg
module rmv_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] a_i,
  input  logic [47:0] b_i,
  output logic        done_o,
  output logic [95:0] prod_o
);
  import rmv_pkg::*;
  logic [95:0] acc_q, acc_d;
  logic [47:0] a_q, a_d;
  logic [47:0] b_q, b_d;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  always_comb begin
    acc_d = acc_q; a_d = a_q; b_d = b_q; cnt_d = cnt_q; busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = '0; a_d = a_i; b_d = b_i; cnt_d = 6'd48; busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {acc_q[94:0], 1'b0} + (b_q[47] ? {48'd0, a_q} : 96'd0);
      b_d = {b_q[46:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end
  assign done_o = done_q;
  assign prod_o = acc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; a_q <= a_d; b_q <= b_d;
  end
endmodule

// File: rtl/running_mean_variance_xy.sv
// top level of the running mean and variance block: sequencer and state
// depends on rmv_pkg, rmv_div, rmv_mul and the assertion macro header
// sequence: divide then multiply for x, then for y, then divide for var_x, var_y and pres_frac;
// with a full count only the last three divides run; otherwise five divider passes and two multiplier
// passes per item in all; one item at a time, input held until the output transfer
// reset: asynchronous, active low, clears count, means, m2 sums and presence count
`include "running_mean_variance_xy_defines.svh"
module running_mean_variance_xy (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,  // pos_x, pos_y
  input  logic         s_axis_tuser,  // present
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [199:0] m_axis_tdata,  // item_count, mean_x, mean_y, var_x, var_y, pres_frac
  output logic         m_axis_tuser   // count_overflow
);
  import rmv_pkg::*;
  localparam logic [3:0] StIdle = 4'd0, StDivX = 4'd1, StMulX = 4'd2, StDivY = 4'd3,
    StMulY = 4'd4, StVarX = 4'd5, StVarY = 4'd6, StRat = 4'd7, StOut = 4'd8;
  logic [3:0] st_q, st_d;
  logic go_q, go_d;
  logic [CountBits-1:0] cnt_q, cnt_d, pc_q, pc_d;
  logic signed [31:0] mx_q, mx_d, my_q, my_d;
  logic [63:0] m2x_q, m2x_d, m2y_q, m2y_d;
  logic signed [CoordBits-1:0] x_q, y_q;
  logic pres_q, drop_q;
  logic signed [48:0] dd_q, dd_d;
  logic [39:0] vx_q, vx_d, vy_q, vy_d;
  logic [16:0] rat_q, rat_d;
  logic in_acc, in_y;
  logic div_start, div_done, mul_start, mul_done;
  logic [DivBits-1:0] div_num, div_quo;
  logic [CountBits-1:0] div_den;
  logic [47:0] mul_a, mul_b;
  logic [95:0] mul_p;
  logic signed [48:0] c_cur, diff, nm_full;
  logic signed [31:0] nm_sat, mean_cur;
  logic [48:0] dmag, diffmag;
  logic [64:0] m2sum;
  logic [63:0] t_val, m2_cur;
  logic [CountBits-1:0] n_val;
  logic [39:0] var_sat;
  rmv_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo));
  rmv_mul u_mul (.clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_p));
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_y = (st_q == StDivY) || (st_q == StMulY);
  assign c_cur = in_y ? (49'(y_q) <<< FracBits) : (49'(x_q) <<< FracBits);
  assign mean_cur = in_y ? my_q : mx_q;
  assign m2_cur = in_y ? m2y_q : m2x_q;
  assign n_val = cnt_q + 1'b1;
  assign diff = c_cur - 49'(mean_cur);
  assign diffmag = diff[48] ? 49'(-diff) : diff;
  assign dmag = dd_q[48] ? 49'(-dd_q) : dd_q;
  assign nm_full = dd_q[48] ? 49'(mean_cur) - $signed({16'd0, div_quo[32:0]}) :
                              49'(mean_cur) + $signed({16'd0, div_quo[32:0]});
  assign nm_sat = (nm_full > 49'sh7fffffff) ? 32'sh7fffffff :
                  (nm_full < -49'sh80000000) ? 32'sh80000000 : nm_full[31:0];
  assign t_val = (mul_p[95:88] != 8'd0) ? '1 : mul_p[87:24];
  assign m2sum = {1'b0, m2_cur} + {1'b0, t_val};
  assign var_sat = (cnt_q < CountBits'(2)) ? '0 :
                   (div_quo[63:40] != '0) ? VarMax : div_quo[39:0];
  always_comb begin
    st_d = st_q; go_d = 1'b0; cnt_d = cnt_q; pc_d = pc_q; mx_d = mx_q; my_d = my_q;
    m2x_d = m2x_q; m2y_d = m2y_q; dd_d = dd_q; vx_d = vx_q; vy_d = vy_q; rat_d = rat_q;
    div_start = 1'b0; mul_start = 1'b0;
    div_num = 64'(diffmag); div_den = n_val;
    mul_a = dmag[47:0];
    mul_b = (dd_q[48] != diff[48]) ? '0 : diffmag[47:0];
    unique case (st_q)
      StIdle: begin
        if (in_acc) begin
          st_d = (cnt_q == CountMax) ? StVarX : StDivX;
          go_d = 1'b1;
        end
      end
      StDivX, StDivY: begin
        if (go_q) begin
          div_start = 1'b1;
          dd_d = diff;
        end else if (div_done) begin
          if (st_q == StDivX) mx_d = nm_sat; else my_d = nm_sat;
          st_d = (st_q == StDivX) ? StMulX : StMulY;
          go_d = 1'b1;
        end
      end
      StMulX, StMulY: begin
        mul_start = go_q;
        if (!go_q && mul_done) begin
          go_d = 1'b1;
          if (st_q == StMulX) begin
            m2x_d = m2sum[64] ? '1 : m2sum[63:0];
            st_d = StDivY;
          end else begin
            m2y_d = m2sum[64] ? '1 : m2sum[63:0];
            cnt_d = n_val; pc_d = pc_q + CountBits'(pres_q);
            st_d = StVarX;
          end
        end
      end
      StVarX, StVarY, StRat: begin
        div_num = (st_q == StVarX) ? m2x_q : (st_q == StVarY) ? m2y_q :
                  64'({pc_q, {FracBits{1'b0}}});
        div_den = (st_q == StRat) ? cnt_q : cnt_q - 1'b1;
        div_start = go_q;
        if (!go_q && div_done) begin
          if (st_q == StVarX) begin
            vx_d = var_sat; st_d = StVarY; go_d = 1'b1;
          end else if (st_q == StVarY) begin
            vy_d = var_sat; st_d = StRat; go_d = 1'b1;
          end else begin
            rat_d = (cnt_q == '0) ? '0 : div_quo[16:0];
            st_d = StOut;
          end
        end
      end
      StOut: begin
        if (m_axis_tready) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; go_q <= 1'b0; cnt_q <= '0; pc_q <= '0; mx_q <= '0; my_q <= '0;
      m2x_q <= '0; m2y_q <= '0;
    end else begin
      st_q <= st_d; go_q <= go_d; cnt_q <= cnt_d; pc_q <= pc_d; mx_q <= mx_d; my_q <= my_d;
      m2x_q <= m2x_d; m2y_q <= m2y_d;
    end
  end
  always_ff @(posedge clk_i) begin
    dd_q <= dd_d; vx_q <= vx_d; vy_q <= vy_d; rat_q <= rat_d;
    if (in_acc) begin
      x_q <= s_axis_tdata[CoordBits-1:0];
      y_q <= s_axis_tdata[16+CoordBits-1:16];
      pres_q <= s_axis_tuser;
      drop_q <= (cnt_q == CountMax);
    end
  end
  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = (st_q == StOut);
  assign m_axis_tdata = {7'd0, rat_q, vy_q, vx_q, my_q, mx_q, cnt_q};
  assign m_axis_tuser = drop_q;
  `RMV_ASSERT_IMPL(a_no_both, s_axis_tready, !m_axis_tvalid)
  `RMV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `RMV_ASSERT_NEXT(a_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
endmodule

// File: sim/running_mean_variance_xy_tb.sv
// testbench for running_mean_variance_xy: directed table then random points,
// each result checked against an in-bench welford predictor or a typed expected result
// depends on rmv_pkg and the running_mean_variance_xy rtl
`timescale 1ns / 1ps
module running_mean_variance_xy_tb;
  import rmv_pkg::*;

  localparam int NumRandom = 1430;
  localparam int QuietFrom = 1300;
  localparam int LongHold  = 3000;
  localparam int Watchdog  = 20000;

  typedef struct packed {
    logic [CountBits-1:0] item_count;
    logic signed [31:0]   mean_x;
    logic signed [31:0]   mean_y;
    logic [39:0]          var_x;
    logic [39:0]          var_y;
    logic [16:0]          pres_frac;
    logic                 count_overflow;
  } stats_t;

  typedef struct {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic                        p;
    logic                        typed;
    stats_t                      res;
  } point_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;  // pos_x, pos_y
  logic         s_axis_tuser = 1'b0;  // present
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;  // item_count, mean_x, mean_y, var_x, var_y, pres_frac
  logic         m_axis_tuser;  // count_overflow

  running_mean_variance_xy dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [CountBits-1:0] n_points;
  logic [CountBits-1:0] n_present;
  longint               avg_x, avg_y;
  logic [63:0]          sumsq_x, sumsq_y;

  stats_t     stats_q[$];
  point_row_t rows[$];
  bit         typed_q[$];
  stats_t     typed_res_q[$];
  int         errors = 0;
  int         points_sent = 0;
  int         stats_seen = 0;
  int         idle_cnt = 0;
  bit         in_xfer = 0;
  bit         quiet = 0;
  bit         hold_done = 0;
  int         present_sent = 0;

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic void welford_step(input longint coord, inout longint avg,
                                       inout logic [63:0] sumsq, input logic [63:0] n);
    longint       c, d, nm, d2;
    logic [63:0]  q, t;
    logic [127:0] prod;
    c  = coord * 65536;
    d  = c - avg;
    q  = mag(d) / n;
    nm = d < 0 ? avg - longint'(q) : avg + longint'(q);
    if (nm > 64'sd2147483647) nm = 64'sd2147483647;
    if (nm < -64'sd2147483648) nm = -64'sd2147483648;
    avg = nm;
    d2 = c - nm;
    t = '0;
    if ((d < 0) == (d2 < 0)) begin
      prod = {64'b0, mag(d)} * {64'b0, mag(d2)};
      t = (prod[127:88] != 0) ? '1 : prod[87:24];
    end
    sumsq = (~sumsq < t) ? '1 : sumsq + t;
  endfunction

  function automatic logic [39:0] sample_var(logic [63:0] sumsq);
    logic [63:0] v;
    if (n_points < 2) return '0;
    v = sumsq / (64'(n_points) - 1);
    return v > 64'(VarMax) ? VarMax : v[39:0];
  endfunction

  function automatic stats_t predict_stats(logic signed [CoordBits-1:0] x,
                                           logic signed [CoordBits-1:0] y, logic p);
    stats_t      r;
    logic [63:0] ratio;
    r.count_overflow = (n_points == CountMax);
    if (!r.count_overflow) begin
      welford_step(longint'(x), avg_x, sumsq_x, 64'(n_points) + 1);
      welford_step(longint'(y), avg_y, sumsq_y, 64'(n_points) + 1);
      if (p) n_present++;
      n_points++;
    end
    r.item_count = n_points;
    r.mean_x = avg_x[31:0];
    r.mean_y = avg_y[31:0];
    r.var_x = sample_var(sumsq_x);
    r.var_y = sample_var(sumsq_y);
    ratio = n_points == 0 ? '0 : (64'(n_present) << FracBits) / 64'(n_points);
    r.pres_frac = ratio[16:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // accept side bookkeeping, prediction and checking
  always @(posedge clk_i) begin
    stats_t e, a;
    in_xfer <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (s_axis_tvalid && s_axis_tready) begin
      e = predict_stats(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tuser);
      if (typed_q.pop_front()) e = typed_res_q.pop_front();
      stats_q.push_back(e);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      a.item_count = m_axis_tdata[31:0];
      a.mean_x = m_axis_tdata[63:32];
      a.mean_y = m_axis_tdata[95:64];
      a.var_x = m_axis_tdata[135:96];
      a.var_y = m_axis_tdata[175:136];
      a.pres_frac = m_axis_tdata[192:176];
      a.count_overflow = m_axis_tuser;
      stats_seen++;
      if (stats_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = stats_q.pop_front();
        check_field("item_count", e.item_count, a.item_count);
        check_field("mean_x", e.mean_x, a.mean_x);
        check_field("mean_y", e.mean_y, a.mean_y);
        check_field("var_x", e.var_x, a.var_x);
        check_field("var_y", e.var_y, a.var_y);
        check_field("pres_frac", e.pres_frac, a.pres_frac);
        check_field("count_overflow", e.count_overflow, a.count_overflow);
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cnt >= Watchdog) begin
      $display("timeout: no transfer for %0d cycles", Watchdog);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int k;
    forever begin
      @(negedge clk_i);
      if (!hold_done && points_sent >= 300) begin
        hold_done = 1;
        m_axis_tready = 1'b0;
        for (k = 0; k < LongHold; k++) @(negedge clk_i);
        m_axis_tready = 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        m_axis_tready = 1'b0;
        k = $urandom_range(1, 18);
        repeat (k) @(negedge clk_i);
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic send_point(point_row_t r);
    int k;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid = 1'b0;
      k = $urandom_range(1, 18);
      repeat (k) @(negedge clk_i);
    end
    typed_q.push_back(r.typed);
    if (r.typed) typed_res_q.push_back(r.res);
    s_axis_tdata = {r.y, r.x};
    s_axis_tuser = r.p;
    s_axis_tvalid = 1'b1;
    do @(negedge clk_i); while (!in_xfer);
    points_sent++;
    if (r.p) present_sent++;
  endtask

  function automatic point_row_t row(int x, int y, bit p);
    point_row_t r;
    r.x = 16'(x);
    r.y = 16'(y);
    r.p = p;
    r.typed = 0;
    r.res = '0;
    return r;
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($signed($urandom_range(0, 31)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    point_row_t r;
    n_points = '0;
    n_present = '0;
    avg_x = 0;
    avg_y = 0;
    sumsq_x = '0;
    sumsq_y = '0;

    // first point after reset: mean is the point itself, no variance yet
    r = row(-32768, 32767, 1);
    r.typed = 1;
    r.res = '{item_count: 1, mean_x: 32'h8000_0000, mean_y: 32'h7fff_0000,
              var_x: '0, var_y: '0, pres_frac: 17'h10000, count_overflow: 0};
    rows.push_back(r);
    // second point: swing to the opposite extremes, variance now defined
    rows.push_back(row(32767, -32768, 0));
    rows.push_back(row(0, 0, 1));
    rows.push_back(row(-1, 1, 0));
    rows.push_back(row(1, -1, 1));
    rows.push_back(row(-32768, -32768, 1));
    rows.push_back(row(-32768, -32768, 0));
    rows.push_back(row(32767, 32767, 1));
    rows.push_back(row(32767, 32767, 1));
    rows.push_back(row(16'h5555, 16'haaaa, 0));
    rows.push_back(row(16'haaaa, 16'h5555, 1));
    rows.push_back(row(0, 0, 0));
    rows.push_back(row(-32768, 32767, 0));
    rows.push_back(row(12345, -12345, 1));

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_point(rows[i]);

    for (int i = 0; i < NumRandom; i++) begin
      if (i == 700) begin
        s_axis_tvalid = 1'b0;
        while (stats_q.size() != 0) @(negedge clk_i);
      end
      if (i == QuietFrom) quiet = 1;
      r = row(0, 0, 0);
      // mostly clustered around a drifting centre, the rest anywhere
      if ($urandom_range(0, 3) != 0) begin
        r.x = 16'($signed($urandom_range(0, 2047)) - 1024 + (i * 13));
        r.y = 16'($signed($urandom_range(0, 2047)) - 1024 - (i * 7));
      end else begin
        r.x = rand_coord();
        r.y = rand_coord();
      end
      r.p = 1'($urandom_range(0, 1));
      send_point(r);
    end
    s_axis_tvalid = 1'b0;

    while (stats_q.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);

    $display("covered %0d points (%0d present), %0d results checked, final count %0d",
             points_sent, present_sent, stats_seen, n_points);
    $display("included coordinate extremes, a long output hold-off and a drain pause");
    if (errors == 0 && stats_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: running_mean_variance_xy.f
+incdir+rtl
rtl/rmv_pkg.sv
rtl/rmv_div.sv
rtl/rmv_mul.sv
rtl/running_mean_variance_xy.sv
sim/running_mean_variance_xy_tb.sv
